### hw/rtl/bmp24_to_rgb565_decoder_unit_defines.svh
// Assertion macros for the BMP decoder; empty when SYNTHESIS is defined.
`ifndef BMP24_TO_RGB565_DECODER_UNIT_DEFINES_SVH
`define BMP24_TO_RGB565_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BMP565_ASSERT_IMPL(name, cond, expr) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("bmp565 check failed");
`define BMP565_ASSERT_NEXT(name, cond, expr) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("bmp565 check failed");
`else
`define BMP565_ASSERT_IMPL(name, cond, expr)
`define BMP565_ASSERT_NEXT(name, cond, expr)
`endif
`endif

### hw/rtl/bmp565_pkg.sv
`timescale 1ns / 1ps
package bmp565_pkg;

    localparam int MAX_DIM_DEFAULT     = 4096;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int COORD_W             = 12;

    // configuration register indexes
    localparam logic [1:0] REG_ORIGIN_X      = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y      = 2'd1;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd2;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

    localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd160;
    localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd128;

    // header byte positions where a field is complete
    localparam logic [31:0] POS_SIG    = 32'd1;
    localparam logic [31:0] POS_OFFSET = 32'd13;
    localparam logic [31:0] POS_WIDTH  = 32'd21;
    localparam logic [31:0] POS_HEIGHT = 32'd25;
    localparam logic [31:0] POS_PLANES = 32'd27;
    localparam logic [31:0] POS_DEPTH  = 32'd29;
    localparam logic [31:0] POS_COMP   = 32'd33;
    localparam logic [31:0] HEADER_LEN = 32'd34;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] BMP_PLANES    = 16'd1;
    localparam logic [15:0] BMP_DEPTH     = 16'd24;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_SKIP   = 4'b0010,
        PH_PIXEL  = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        OP_BLUE   = 2'd0,
        OP_GREEN  = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_REJECT = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         data;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } q_entry_t;

    typedef struct packed {
        logic [7:0]  origin_x;
        logic [7:0]  origin_y;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
    } cfg_t;

endpackage

### hw/rtl/bmp565_queue.sv
`timescale 1ns / 1ps
module bmp565_queue #(
    parameter int DEPTH = bmp565_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  bmp565_pkg::q_entry_t push_entry,
    input  logic                 pop,
    output bmp565_pkg::q_entry_t head,
    output logic                 empty,
    output logic                 full
);
    import bmp565_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t        slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/bmp565_parse.sv
`timescale 1ns / 1ps
module bmp565_parse #(
    parameter int MAX_DIM = bmp565_pkg::MAX_DIM_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_en,
    input  logic [7:0]           file_byte,
    input  logic                 start_of_file,
    input  bmp565_pkg::cfg_t     cfg,
    output logic                 push,
    output bmp565_pkg::q_entry_t push_entry
);
    import bmp565_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam logic [1:0] K_LAST = 2'd2;

    phase_t             phase_reg, phase_next, phase_cur;
    logic [31:0]        byte_count_reg, byte_count_next, byte_count_cur;
    logic [31:0]        shift_reg, shift_next;
    logic [31:0]        offset_reg, offset_next;
    logic               header_bad_reg, header_bad_next, bad_cur;
    logic               bottom_up_reg, bottom_up_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [DIM_W-1:0]   vis_w_reg, vis_w_next;
    logic [DIM_W-1:0]   vis_h_reg, vis_h_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [DIM_W-1:0]   irow_reg, irow_next;
    logic [1:0]         k_reg, k_next;
    logic [1:0]         pad_reg, pad_next;

    logic [31:0]        height_mag;
    logic [12:0]        room_x, room_y;
    logic [DIM_W-1:0]   vis_w_calc, vis_h_calc;
    logic [DIM_W-1:0]   last_vis_row, row_stop;
    logic               origin_off, offset_reached, do_pixel, visible, at_last, row_end;

    always_comb begin
        phase_cur      = start_of_file ? PH_HEADER : phase_reg;
        byte_count_cur = start_of_file ? '0 : byte_count_reg;
        bad_cur        = start_of_file ? 1'b0 : header_bad_reg;

        room_x = cfg.screen_width - {5'd0, cfg.origin_x};
        room_y = cfg.screen_height - {5'd0, cfg.origin_y};
        origin_off = ({5'd0, cfg.origin_x} >= cfg.screen_width)
                  || ({5'd0, cfg.origin_y} >= cfg.screen_height);
        vis_w_calc = (32'(width_reg) < 32'(room_x)) ? width_reg : DIM_W'(room_x);
        vis_h_calc = (32'(height_reg) < 32'(room_y)) ? height_reg : DIM_W'(room_y);

        shift_next = {file_byte, shift_reg[31:8]};
        height_mag = shift_next[31] ? (32'd0 - shift_next) : shift_next;

        offset_reached = !(byte_count_cur < offset_reg);
        do_pixel = byte_en && ((phase_cur == PH_PIXEL)
                            || (phase_cur == PH_SKIP && offset_reached));

        last_vis_row = bottom_up_reg ? '0 : vis_h_reg - DIM_W'(1);
        row_stop     = bottom_up_reg ? '0 : height_reg - DIM_W'(1);
        visible = (col_reg < vis_w_reg) && (irow_reg < vis_h_reg);
        at_last = (col_reg == vis_w_reg - DIM_W'(1)) && (irow_reg == last_vis_row);
        row_end = 1'b0;

        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        header_bad_next = header_bad_reg;
        offset_next     = offset_reg;
        bottom_up_next  = bottom_up_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        vis_w_next      = vis_w_reg;
        vis_h_next      = vis_h_reg;
        col_next        = col_reg;
        irow_next       = irow_reg;
        k_next          = k_reg;
        pad_next        = pad_reg;
        push            = 1'b0;
        push_entry      = '0;

        if (byte_en) begin
            phase_next      = phase_cur;
            byte_count_next = byte_count_cur;
            header_bad_next = bad_cur;
            case (phase_cur)
                PH_HEADER: begin
                    byte_count_next = byte_count_cur + 32'd1;
                    case (byte_count_cur)
                        POS_SIG: begin
                            if (shift_next[31:16] != BMP_SIGNATURE) header_bad_next = 1'b1;
                        end
                        POS_OFFSET: begin
                            offset_next = shift_next;
                            if (shift_next < HEADER_LEN) header_bad_next = 1'b1;
                        end
                        POS_WIDTH: begin
                            // a negative width shows up here as a huge value
                            if (shift_next > 32'(MAX_DIM)) header_bad_next = 1'b1;
                            else width_next = DIM_W'(shift_next);
                        end
                        POS_HEIGHT: begin
                            bottom_up_next = !shift_next[31];
                            if (height_mag > 32'(MAX_DIM)) header_bad_next = 1'b1;
                            else height_next = DIM_W'(height_mag);
                        end
                        POS_PLANES: begin
                            if (shift_next[31:16] != BMP_PLANES) header_bad_next = 1'b1;
                        end
                        POS_DEPTH: begin
                            if (shift_next[31:16] != BMP_DEPTH) header_bad_next = 1'b1;
                        end
                        POS_COMP: begin
                            if (bad_cur || shift_next != 32'd0) begin
                                phase_next    = PH_DONE;
                                push          = 1'b1;
                                push_entry.op = OP_REJECT;
                            end else if (origin_off) begin
                                phase_next = PH_DONE;
                            end else if (vis_w_calc == '0 || vis_h_calc == '0) begin
                                phase_next = PH_DONE;
                            end else begin
                                vis_w_next = vis_w_calc;
                                vis_h_next = vis_h_calc;
                                col_next   = '0;
                                k_next     = '0;
                                pad_next   = '0;
                                irow_next  = bottom_up_reg ? height_reg - DIM_W'(1) : '0;
                                phase_next = PH_SKIP;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_SKIP: begin
                    if (!offset_reached) byte_count_next = byte_count_cur + 32'd1;
                    else phase_next = PH_PIXEL;
                end
                default: ;
            endcase
        end

        if (do_pixel) begin
            if (col_reg < width_reg) begin
                if (visible) begin
                    push            = 1'b1;
                    push_entry.data = file_byte;
                    push_entry.col  = COORD_W'(col_reg);
                    push_entry.row  = COORD_W'(irow_reg);
                    case (k_reg)
                        2'd0:    push_entry.op = OP_BLUE;
                        2'd1:    push_entry.op = OP_GREEN;
                        default: begin
                            push_entry.op   = OP_PIXEL;
                            push_entry.last = at_last;
                        end
                    endcase
                end
                if (k_reg == K_LAST) begin
                    k_next   = '0;
                    col_next = col_reg + DIM_W'(1);
                    if (visible && at_last) phase_next = PH_DONE;
                    // rows of a multiple of four pixels carry no padding
                    row_end = (col_reg == width_reg - DIM_W'(1)) && (width_reg[1:0] == 2'd0);
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end else begin
                // padding length is width mod 4
                pad_next = pad_reg + 2'd1;
                row_end  = (pad_reg == width_reg[1:0] - 2'd1);
            end
            if (row_end) begin
                col_next = '0;
                k_next   = '0;
                pad_next = '0;
                if (irow_reg == row_stop) phase_next = PH_DONE;
                else irow_next = bottom_up_reg ? irow_reg - DIM_W'(1) : irow_reg + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            byte_count_reg <= '0;
            header_bad_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            header_bad_reg <= header_bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_en) begin
            shift_reg <= shift_next;
        end
        offset_reg    <= offset_next;
        bottom_up_reg <= bottom_up_next;
        width_reg     <= width_next;
        height_reg    <= height_next;
        vis_w_reg     <= vis_w_next;
        vis_h_reg     <= vis_h_next;
        col_reg       <= col_next;
        irow_reg      <= irow_next;
        k_reg         <= k_next;
        pad_reg       <= pad_next;
    end

endmodule

### hw/rtl/bmp565_emit.sv
`timescale 1ns / 1ps
module bmp565_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  bmp565_pkg::q_entry_t head,
    input  bmp565_pkg::cfg_t     cfg,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);
    import bmp565_pkg::*;

    logic                valid_reg, valid_next;
    logic [7:0]          blue_reg, blue_next;
    logic [7:0]          green_reg, green_next;
    logic [39:0]         data_reg, data_next;
    logic                kind_reg, kind_next;
    logic                last_reg, last_next;
    logic                out_free, head_hold;
    logic [COORD_W-1:0]  scr_col, scr_row;
    logic [15:0]         color;

    assign out_free  = !valid_reg || m_tready;
    assign head_hold = (head.op == OP_BLUE) || (head.op == OP_GREEN);
    assign q_pop     = !q_empty && (head_hold || out_free);

    assign scr_col = COORD_W'(cfg.origin_x) + head.col;
    assign scr_row = COORD_W'(cfg.origin_y) + head.row;
    assign color   = {head.data[7:3], green_reg[7:2], blue_reg[7:3]};

    always_comb begin
        valid_next = valid_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        data_next  = data_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        if (out_free) valid_next = 1'b0;
        if (q_pop) begin
            case (head.op)
                OP_BLUE:  blue_next = head.data;
                OP_GREEN: green_next = head.data;
                OP_PIXEL: begin
                    valid_next = 1'b1;
                    data_next  = {color, scr_row, scr_col};
                    kind_next  = 1'b0;
                    last_next  = head.last;
                end
                default: begin
                    valid_next = 1'b1;
                    data_next  = '0;
                    kind_next  = 1'b1;
                    last_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        blue_reg  <= blue_next;
        green_reg <= green_next;
        data_reg  <= data_next;
        kind_reg  <= kind_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

### hw/rtl/bmp24_to_rgb565_decoder_unit.sv
`timescale 1ns / 1ps
// Red byte (or header byte 33) path: queue, then the output register driving m_tvalid.
// Throughput: one file byte per cycle while the queue is not full (s_tready is !q_full);
// at most one result leaves per three pixel bytes.
// Reset: aresetn is synchronous, active low; it restarts the parse at byte 0, empties the
// queue and output stage, and loads origin 0,0 and screen 160x128.
`include "bmp24_to_rgb565_decoder_unit_defines.svh"
module bmp24_to_rgb565_decoder_unit #(
    parameter int MAX_DIM     = bmp565_pkg::MAX_DIM_DEFAULT,
    parameter int QUEUE_DEPTH = bmp565_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] file_byte
    input  logic        s_tuser,   // [0] start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [11:0] screen_col, [23:12] screen_row, [39:24] color
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast,   // last_pixel
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);
    import bmp565_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     byte_en;
    logic     q_push, q_pop, q_empty, q_full;
    q_entry_t q_in, q_head;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ORIGIN_X:     cfg_next.origin_x = cfg_wdata[7:0];
                REG_ORIGIN_Y:     cfg_next.origin_y = cfg_wdata[7:0];
                REG_SCREEN_WIDTH: cfg_next.screen_width = cfg_wdata;
                default:          cfg_next.screen_height = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{origin_x: 8'd0, origin_y: 8'd0,
                         screen_width: SCREEN_WIDTH_RESET,
                         screen_height: SCREEN_HEIGHT_RESET};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !q_full;
    assign byte_en  = s_tvalid && s_tready;

    bmp565_parse #(
        .MAX_DIM(MAX_DIM)
    ) u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_en      (byte_en),
        .file_byte    (s_tdata),
        .start_of_file(s_tuser),
        .cfg          (cfg_reg),
        .push         (q_push),
        .push_entry   (q_in)
    );

    bmp565_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    bmp565_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .head    (q_head),
        .cfg     (cfg_reg),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    `BMP565_ASSERT_IMPL(a_reject_payload_zero, m_tvalid && m_tuser, m_tdata == '0 && !m_tlast)
    `BMP565_ASSERT_IMPL(a_no_pop_when_empty, q_pop, !q_empty)
    `BMP565_ASSERT_IMPL(a_no_push_when_full, q_push, !q_full)
    `BMP565_ASSERT_NEXT(a_push_fills_queue, q_push && !q_pop, !q_empty)

endmodule

### verif/bmp24_to_rgb565_decoder_unit_tb.sv
`timescale 1ns / 1ps
module bmp24_to_rgb565_decoder_unit_tb;
    import bmp565_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int DRAIN_LIMIT    = 20_000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RANDOM_BYTES   = 200;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [31:0] DIM_LIMIT = 32'(MAX_DIM_DEFAULT);

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [11:0] col;
        logic [11:0] row;
        logic [15:0] color;
        logic        last;
    } pixel_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = REG_ORIGIN_X;
    logic [12:0] cfg_wdata = 13'd0;

    bmp24_to_rgb565_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] file_byte
        .s_tuser   (s_tuser),   // [0] start_of_file
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [11:0] screen_col, [23:12] screen_row, [39:24] color
        .m_tuser   (m_tuser),   // [0] kind
        .m_tlast   (m_tlast),   // last_pixel
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #CLK_HALF;
        aclk = 1'b0;
        #CLK_HALF;
    end

    // decoder shadow: configuration
    logic [31:0] cfg_ox = 32'd0;
    logic [31:0] cfg_oy = 32'd0;
    logic [31:0] cfg_sw = 32'(SCREEN_WIDTH_RESET);
    logic [31:0] cfg_sh = 32'(SCREEN_HEIGHT_RESET);

    // decoder shadow: parse state
    logic [31:0] byte_count, hdr_shift, pix_offset, img_w, img_h;
    logic [31:0] row_byte, src_row, shown_count, vis_w, vis_h, padded_row;
    logic [7:0]  blue_hold, green_hold;
    logic        bottom_up, hdr_bad;
    phase_t      parse_phase;

    pixel_result_t pending_pixels[$];
    logic [7:0]    file_bytes[$];

    int failures = 0;
    int bytes_sent = 0;
    int burst_left = 0;

    task automatic log_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT) $display("%s", msg);
    endtask

    task automatic restart_parse();
        byte_count = 0; hdr_shift = 0; pix_offset = 0;
        img_w = 0; img_h = 0; bottom_up = 1'b1;
        parse_phase = PH_HEADER; row_byte = 0; src_row = 0;
        blue_hold = 0; green_hold = 0; shown_count = 0;
        hdr_bad = 1'b0; vis_w = 0; vis_h = 0; padded_row = 0;
    endtask

    // Advances the shadow decoder by one file byte and queues any result it produces.
    task automatic decode_byte(input logic [7:0] b, input logic sof);
        logic [31:0]   pos, mag, bi, col, irow;
        pixel_result_t r;
        r = '0;
        if (sof) restart_parse();
        if (parse_phase == PH_HEADER) begin
            pos = byte_count;
            hdr_shift = {b, hdr_shift[31:8]};
            byte_count++;
            case (pos)
                POS_SIG: if (hdr_shift[31:16] != BMP_SIGNATURE) hdr_bad = 1'b1;
                POS_OFFSET: begin
                    pix_offset = hdr_shift;
                    if (pix_offset < HEADER_LEN) hdr_bad = 1'b1;
                end
                POS_WIDTH: begin
                    if (hdr_shift > DIM_LIMIT) hdr_bad = 1'b1;
                    else img_w = hdr_shift;
                end
                POS_HEIGHT: begin
                    mag = hdr_shift;
                    bottom_up = 1'b1;
                    if (hdr_shift[31]) begin
                        mag = -hdr_shift;
                        bottom_up = 1'b0;
                    end
                    if (mag > DIM_LIMIT) hdr_bad = 1'b1;
                    else img_h = mag;
                end
                POS_PLANES: if (hdr_shift[31:16] != BMP_PLANES) hdr_bad = 1'b1;
                POS_DEPTH: if (hdr_shift[31:16] != BMP_DEPTH) hdr_bad = 1'b1;
                POS_COMP: begin
                    if (hdr_shift != 0) hdr_bad = 1'b1;
                    if (hdr_bad) begin
                        parse_phase = PH_DONE;
                        r.kind = KIND_REJECT;
                        pending_pixels.push_back(r);
                    end else if (cfg_ox >= cfg_sw || cfg_oy >= cfg_sh) begin
                        parse_phase = PH_DONE;
                    end else begin
                        vis_w = (img_w < cfg_sw - cfg_ox) ? img_w : cfg_sw - cfg_ox;
                        vis_h = (img_h < cfg_sh - cfg_oy) ? img_h : cfg_sh - cfg_oy;
                        if (vis_w == 0 || vis_h == 0) begin
                            parse_phase = PH_DONE;
                        end else begin
                            padded_row = (img_w * 3 + 3) & ~32'd3;
                            parse_phase = PH_SKIP;
                        end
                    end
                end
                default: ;
            endcase
        end else if (parse_phase == PH_SKIP && byte_count < pix_offset) begin
            byte_count++;
        end else begin
            if (parse_phase == PH_SKIP) parse_phase = PH_PIXEL;
            if (parse_phase == PH_PIXEL) begin
                bi = row_byte;
                if (bi < img_w * 3) begin
                    if (bi % 3 == 0) begin
                        blue_hold = b;
                    end else if (bi % 3 == 1) begin
                        green_hold = b;
                    end else begin
                        col = bi / 3;
                        irow = bottom_up ? img_h - 1 - src_row : src_row;
                        if (col < vis_w && irow < vis_h) begin
                            shown_count++;
                            r.kind  = KIND_PIXEL;
                            r.col   = 12'(cfg_ox + col);
                            r.row   = 12'(cfg_oy + irow);
                            r.color = {b[7:3], green_hold[7:2], blue_hold[7:3]};
                            r.last  = (shown_count == vis_w * vis_h);
                            if (r.last) parse_phase = PH_DONE;
                            pending_pixels.push_back(r);
                        end
                    end
                end
                bi++;
                if (bi >= padded_row) begin
                    bi = 0;
                    src_row++;
                    if (src_row >= img_h) parse_phase = PH_DONE;
                end
                row_byte = bi;
            end
        end
    endtask

    // Prediction runs on each accepted input transaction, checking on each output one.
    always @(posedge aclk) begin : scoreboard
        pixel_result_t want, got;
        if (aresetn) begin
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                got.kind  = m_tuser;
                got.col   = m_tdata[11:0];
                got.row   = m_tdata[23:12];
                got.color = m_tdata[39:24];
                got.last  = m_tlast;
                if (pending_pixels.size() == 0) begin
                    log_failure($sformatf("unexpected result: kind=%0d col=%0d row=%0d color=%h last=%0d",
                        got.kind, got.col, got.row, got.color, got.last));
                end else begin
                    want = pending_pixels.pop_front();
                    if (got !== want)
                        log_failure($sformatf(
                            "mismatch: exp kind=%0d col=%0d row=%0d color=%h last=%0d, got kind=%0d col=%0d row=%0d color=%h last=%0d",
                            want.kind, want.col, want.row, want.color, want.last,
                            got.kind, got.col, got.row, got.color, got.last));
                end
            end
        end
    end

    // receiver backpressure, pattern picked anew whenever the low nine bits of stall_tick are zero
    logic [15:0] stall_tick = 16'd0;
    logic [1:0]  stall_mode = 2'd0;
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 16'd1;
        if (stall_tick[8:0] == 9'd0) stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= (stall_tick[2:0] != 3'd7);
            2'd2: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= stall_tick[3];
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic sof);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 64);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_file(input logic mark);
        foreach (file_bytes[i]) send_byte(file_bytes[i], mark && (i == 0));
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_pixels.size() != 0) begin
            log_failure($sformatf("%0d expected results never arrived", pending_pixels.size()));
            pending_pixels.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // all four registers on consecutive cycles, enable held high throughout
    task automatic set_screen(input int ox, input int oy, input int sw, input int sh);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_ORIGIN_X;
        cfg_wdata <= 13'(ox);
        @(posedge aclk);
        cfg_addr  <= REG_ORIGIN_Y;
        cfg_wdata <= 13'(oy);
        @(posedge aclk);
        cfg_addr  <= REG_SCREEN_WIDTH;
        cfg_wdata <= 13'(sw);
        @(posedge aclk);
        cfg_addr  <= REG_SCREEN_HEIGHT;
        cfg_wdata <= 13'(sh);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_ox = ox & 32'hFF;
        cfg_oy = oy & 32'hFF;
        cfg_sw = sw & 32'h1FFF;
        cfg_sh = sh & 32'h1FFF;
    endtask

    task automatic push_le(input logic [31:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++) file_bytes.push_back(value[8*i +: 8]);
    endtask

    task automatic build_bmp(input logic [15:0] sig, input logic [31:0] offset,
                             input logic [31:0] width, input logic [31:0] height,
                             input logic [15:0] planes, input logic [15:0] depth,
                             input logic [31:0] comp);
        logic [31:0] mag, row_len;
        file_bytes.delete();
        push_le(32'(sig), 2);
        push_le($urandom, 4);     // file size, unused
        push_le($urandom, 4);     // reserved
        push_le(offset, 4);
        push_le($urandom, 4);     // info header size, unused
        push_le(width, 4);
        push_le(height, 4);
        push_le(32'(planes), 2);
        push_le(32'(depth), 2);
        push_le(comp, 4);
        for (logic [31:0] i = HEADER_LEN; i < offset; i++) file_bytes.push_back(8'($urandom));
        mag = height[31] ? -height : height;
        if (width <= DIM_LIMIT && mag <= DIM_LIMIT) begin
            row_len = (width * 3 + 3) & ~32'd3;
            repeat (row_len * mag)
                file_bytes.push_back(($urandom_range(0, 3) == 0) ? {8{1'($urandom)}}
                                                                 : 8'($urandom));
        end
    endtask

    task automatic build_image(input logic [31:0] offset, input int w, input int h);
        build_bmp(BMP_SIGNATURE, offset, 32'(w), 32'(h), BMP_PLANES, BMP_DEPTH, 32'd0);
    endtask

    task automatic trim_file(input int n);
        if (n < file_bytes.size()) file_bytes = file_bytes[0:n-1];
    endtask

    task automatic add_trailing(input int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endtask

    function automatic int pick_origin();
        case ($urandom_range(0, 9))
            0: return 255;
            1, 2: return 0;
            default: return $urandom_range(0, 6);
        endcase
    endfunction

    function automatic int pick_extent();
        case ($urandom_range(0, 9))
            0: return 1;
            1: return 4096;
            2: return 160;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // first file right after reset carries no start flag
    task automatic test_no_start_mark();
        build_image(34, 2, 2);
        send_file(1'b0);
        build_image(34, 3, -2);
        send_file(1'b1);
    endtask

    task automatic test_header_rejects();
        logic [15:0] sig, pl, dp;
        logic [31:0] ofs, w, h, cp;
        set_screen(0, 0, 160, 128);
        for (int c = 0; c < 10; c++) begin
            sig = BMP_SIGNATURE; ofs = 34; w = 2; h = 2;
            pl = BMP_PLANES; dp = BMP_DEPTH; cp = 0;
            case (c)
                0: sig = 16'h4D43;
                1: sig = 16'h424D;
                2: ofs = 33;
                3: w = 4097;
                4: w = 32'hFFFF_FFFF;     // negative width
                5: h = 4097;
                6: h = -32'd4097;
                7: pl = 16'd0;
                8: dp = 16'd32;
                default: cp = 32'd1;
            endcase
            build_bmp(sig, ofs, w, h, pl, dp, cp);
            trim_file(40);
            send_file(1'b1);
        end
        // header cut short, then a good file
        build_image(34, 1, 1);
        trim_file(33);
        send_file(1'b1);
        build_image(34, 1, 1);
        send_file(1'b1);
    endtask

    // widest and tallest accepted images, plus a 1x300 image, each cut short early in its pixel data
    task automatic test_dimension_limits();
        set_screen(255, 255, 4096, 256);
        build_image(34, 4096, 1);
        trim_file(34 + 3 * 6);
        send_file(1'b1);
        set_screen(0, 0, 2, 3);
        build_image(34, 1, -4096);
        trim_file(34 + 4 * 5);
        send_file(1'b1);
        set_screen(0, 0, 1, 4096);
        build_image(34, 1, 300);
        trim_file(34 + 4 * 10);
        send_file(1'b1);
    endtask

    task automatic test_origin_and_crop();
        set_screen(255, 0, 100, 128);
        build_image(34, 2, 2);
        send_file(1'b1);
        set_screen(0, 255, 160, 255);
        build_image(34, 2, 2);
        send_file(1'b1);
        set_screen(0, 0, 1, 1);
        build_image(34, 3, 3);
        send_file(1'b1);
        set_screen(159, 127, 160, 128);
        build_image(34, 2, 2);
        send_file(1'b1);
        set_screen(5, 7, 8, 9);
        build_image(34, 5, 4);
        send_file(1'b1);
        build_image(34, 5, -4);
        send_file(1'b1);
    endtask

    task automatic test_empty_image();
        set_screen(0, 0, 160, 128);
        build_image(34, 0, 3);
        add_trailing(10);
        send_file(1'b1);
        build_image(34, 3, 0);
        add_trailing(10);
        send_file(1'b1);
        build_image(34, 0, -2);
        send_file(1'b1);
    endtask

    task automatic test_skip_and_trailing();
        set_screen(3, 4, 160, 128);
        build_image(34, 2, 1);
        add_trailing(15);
        send_file(1'b1);
        build_image(90, 3, 2);
        add_trailing(15);
        send_file(1'b1);
        build_image(600, 2, 2);
        trim_file(120);
        send_file(1'b1);
        build_image(35, 1, 1);
        send_file(1'b1);
    endtask

    task automatic test_random_files();
        int start_count, files, pick, w, h;
        logic [31:0] ofs;
        start_count = bytes_sent;
        files = 0;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            if (files % 3 == 0) set_screen(pick_origin(), pick_origin(), pick_extent(), pick_extent());
            files++;
            pick = $urandom_range(0, 99);
            w = $urandom_range(0, 5);
            h = $urandom_range(0, 5);
            if ($urandom_range(0, 1)) h = -h;
            ofs = 34 + $urandom_range(0, 12);
            if (pick < 70) begin
                build_image(ofs, w, h);
                if ($urandom_range(0, 9) == 0) trim_file($urandom_range(34, file_bytes.size()));
                if ($urandom_range(0, 2) == 0) add_trailing($urandom_range(1, 10));
                send_file($urandom_range(0, 19) != 0);
            end else if (pick < 85) begin
                // one header field broken
                case ($urandom_range(0, 6))
                    0: build_bmp(16'($urandom), ofs, 32'(w), 32'(h), BMP_PLANES, BMP_DEPTH, 0);
                    1: build_bmp(BMP_SIGNATURE, $urandom_range(0, 33), 32'(w), 32'(h),
                                 BMP_PLANES, BMP_DEPTH, 0);
                    2: build_bmp(BMP_SIGNATURE, ofs,
                                 $urandom_range(0, 1) ? $urandom_range(4097, 70000)
                                                      : ($urandom | 32'h8000_0000),
                                 32'(h), BMP_PLANES, BMP_DEPTH, 0);
                    3: build_bmp(BMP_SIGNATURE, ofs, 32'(w),
                                 $urandom_range(0, 1) ? $urandom_range(4097, 70000)
                                                      : -32'($urandom_range(4097, 70000)),
                                 BMP_PLANES, BMP_DEPTH, 0);
                    4: build_bmp(BMP_SIGNATURE, ofs, 32'(w), 32'(h), 16'($urandom),
                                 BMP_DEPTH, 0);
                    5: build_bmp(BMP_SIGNATURE, ofs, 32'(w), 32'(h), BMP_PLANES,
                                 16'($urandom), 0);
                    default: build_bmp(BMP_SIGNATURE, ofs, 32'(w), 32'(h), BMP_PLANES, BMP_DEPTH,
                                       $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom);
                endcase
                trim_file(34 + $urandom_range(0, 8));
                send_file(1'b1);
            end else if (pick < 93) begin
                build_image(ofs, w, h);
                trim_file($urandom_range(1, 33));
                send_file(1'b1);
            end else begin
                repeat ($urandom_range(5, 60)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
            end
        end
    endtask

    initial begin
        restart_parse();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_no_start_mark();
        test_header_rejects();
        test_dimension_limits();
        test_origin_and_crop();
        test_empty_image();
        test_skip_and_trailing();
        test_random_files();
        wait_idle();
        if (failures == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(64'(2 * CLK_HALF) * TIMEOUT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule
